@@ design/hkm_pkg.sv @@
// ============================================================================
// hkm_pkg: shared types and constants of the key to matrix mapper
// Command and register codes, keymap entry layout, the queued operation
// record and the joystick key set match helpers.
// ============================================================================
package hkm_pkg;

   // Default geometry, handed to the top level parameters
   localparam int KEY_CODES_DEF   = 128;
   localparam int MATRIX_ROWS_DEF = 8;
   localparam int MATRIX_COLS_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Field widths fixed by the interface
   localparam int CODE_W      = 7;
   localparam int POS_W       = 8;
   localparam int JOY_W       = 5;
   localparam int MATRIX_W    = 64;
   localparam int KEY_SET_W   = JOY_W * CODE_W;
   localparam int CSR_DATA_W  = KEY_SET_W;
   localparam int CSR_INDEX_W = 2;
   localparam int SOURCE_W    = 2;

   localparam logic [POS_W-1:0]     NO_POSITION      = 8'hff;
   localparam logic [CODE_W-1:0]    SHIFT_LEFT_CODE  = 7'd3;
   localparam logic [CODE_W-1:0]    SHIFT_RIGHT_CODE = 7'd6;
   localparam logic [KEY_SET_W-1:0] KEY_SET_ONE_RESET = 35'd16367937132;
   localparam logic [KEY_SET_W-1:0] KEY_SET_TWO_RESET = 35'd22420154691;

   typedef enum logic [1:0] {
      CMD_LOAD_ENTRY  = 2'd0,
      CMD_FRAME_START = 2'd1,
      CMD_KEY_DOWN    = 2'd2,
      CMD_FRAME_END   = 2'd3
   } command_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEYS_SET_ONE = 2'd0,
      CSR_KEYS_SET_TWO = 2'd1,
      CSR_PORT_ONE_SRC = 2'd2,
      CSR_PORT_TWO_SRC = 2'd3
   } csr_index_type;

   typedef enum logic [SOURCE_W-1:0] {
      SRC_NONE    = 2'd0,
      SRC_SET_ONE = 2'd1,
      SRC_SET_TWO = 2'd2
   } joy_source_type;

   // One keymap entry as held in the keymap memory
   typedef struct packed {
      logic [POS_W-1:0] normal_position;
      logic             normal_adds_shift;
      logic [POS_W-1:0] shifted_position;
      logic             shifted_keeps_shift;
   } map_entry_type;

   localparam map_entry_type MAP_ENTRY_RESET = '{
      normal_position:     NO_POSITION,
      normal_adds_shift:   1'b0,
      shifted_position:    NO_POSITION,
      shifted_keeps_shift: 1'b0
   };

   // Classified transaction passed from the front end to the back end
   typedef struct packed {
      command_type      command;
      logic             code_valid;
      logic             shift_code;
      logic             shift_slot;
      logic             newly_pressed;
      logic [JOY_W-1:0] joy_one;
      logic [JOY_W-1:0] joy_two;
      logic             caps_lock;
      map_entry_type    entry;
   } op_type;

   // Joystick bit of a code within a key set; the lowest slot wins
   function automatic logic [JOY_W-1:0] joy_match(input logic [KEY_SET_W-1:0] key_set,
                                                  input logic [CODE_W-1:0] code);
      logic [JOY_W-1:0] hit;
      hit = '0;
      for (int i = JOY_W - 1; i >= 0; i--) begin
         if (key_set[i*CODE_W +: CODE_W] == code) begin
            hit = JOY_W'(1) << i;
         end
      end
      return hit;
   endfunction

   function automatic logic [JOY_W-1:0] joy_for_port(input logic [SOURCE_W-1:0] source,
                                                     input logic [KEY_SET_W-1:0] set_one,
                                                     input logic [KEY_SET_W-1:0] set_two,
                                                     input logic [CODE_W-1:0] code);
      logic [JOY_W-1:0] bits;
      case (joy_source_type'(source))
         SRC_SET_ONE: begin
            bits = joy_match(set_one, code);
         end
         SRC_SET_TWO: begin
            bits = joy_match(set_two, code);
         end
         default: begin
            bits = '0;
         end
      endcase
      return bits;
   endfunction

endpackage

@@ design/hkm_req_if.sv @@
// ============================================================================
// hkm_req_if: request channel of the key to matrix mapper
// Valid/ready channel carrying one command with its key and keymap fields.
// ============================================================================
interface hkm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [6:0] key_code;
   logic [7:0] normal_position;
   logic       normal_adds_shift;
   logic [7:0] shifted_position;
   logic       shifted_keeps_shift;
   logic       caps_lock;

   modport source (
      output valid, command, key_code, normal_position, normal_adds_shift,
             shifted_position, shifted_keeps_shift, caps_lock,
      input  ready
   );

   modport sink (
      input  valid, command, key_code, normal_position, normal_adds_shift,
             shifted_position, shifted_keeps_shift, caps_lock,
      output ready
   );
endinterface

@@ design/hkm_rsp_if.sv @@
// ============================================================================
// hkm_rsp_if: response channel of the key to matrix mapper
// Valid/ready channel carrying one result per command.
// ============================================================================
interface hkm_rsp_if;
   logic        valid;
   logic        ready;
   logic        newly_pressed;
   logic        frame_valid;
   logic [63:0] key_matrix;
   logic [4:0]  joystick_one;
   logic [4:0]  joystick_two;

   modport source (
      output valid, newly_pressed, frame_valid, key_matrix, joystick_one, joystick_two,
      input  ready
   );

   modport sink (
      input  valid, newly_pressed, frame_valid, key_matrix, joystick_one, joystick_two,
      output ready
   );
endinterface

@@ design/hkm_ram.sv @@
// ============================================================================
// hkm_ram: generic single write port RAM
// One write and one registered read per clock.
// ============================================================================
module hkm_ram #(
   parameter  int WIDTH  = 8,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hkm_front.sv @@
// ============================================================================
// hkm_front: accept and classify stage
// Holds the configuration, the keymap memory with its written bits and the
// per-frame key history; reads the keymap and forwards a classified
// operation into the queue.
// ============================================================================
module hkm_front import hkm_pkg::*; #(
   parameter int KEY_CODES = KEY_CODES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   hkm_req_if.sink                req,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output logic                   push_valid,
   input  logic                   push_ready,
   output op_type                 push_op
);

   localparam int IDX_W = $clog2(KEY_CODES);
   localparam logic [CODE_W+1:0] KEY_LIMIT = (CODE_W+2)'(KEY_CODES);

   logic [KEY_SET_W-1:0] key_set_one_ff, key_set_two_ff;
   logic [SOURCE_W-1:0]  port_one_src_ff, port_two_src_ff;

   logic [KEY_CODES-1:0] written_ff, written_in;
   logic [KEY_CODES-1:0] keys_this_ff, keys_this_in;
   logic [KEY_CODES-1:0] keys_last_ff, keys_last_in;

   logic                    f1_valid_ff, f1_valid_in;
   op_type                  f1_op_ff, f1_op_in;
   logic                    f1_from_ram_ff;
   logic                    f1_written_ff;

   command_type             cmd;
   logic                    advance;
   logic                    accept;
   logic                    code_valid;
   logic [CODE_W+IDX_W-1:0] code_ext;
   logic [IDX_W-1:0]        idx;
   map_entry_type           load_entry;
   logic [$bits(map_entry_type)-1:0] ram_rd_data;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_set_one_ff  <= KEY_SET_ONE_RESET;
         key_set_two_ff  <= KEY_SET_TWO_RESET;
         port_one_src_ff <= SRC_NONE;
         port_two_src_ff <= SRC_NONE;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_KEYS_SET_ONE: begin
               key_set_one_ff <= csr_write_data;
            end
            CSR_KEYS_SET_TWO: begin
               key_set_two_ff <= csr_write_data;
            end
            CSR_PORT_ONE_SRC: begin
               port_one_src_ff <= csr_write_data[SOURCE_W-1:0];
            end
            CSR_PORT_TWO_SRC: begin
               port_two_src_ff <= csr_write_data[SOURCE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Decode the incoming transaction
   assign cmd        = command_type'(req.command);
   assign advance    = !f1_valid_ff || push_ready;
   assign req.ready  = advance;
   assign accept     = req.valid && advance;
   assign code_ext   = {{IDX_W{1'b0}}, req.key_code};
   assign idx        = code_ext[IDX_W-1:0];
   assign code_valid = {2'b00, req.key_code} < KEY_LIMIT;

   assign load_entry = '{
      normal_position:     req.normal_position,
      normal_adds_shift:   req.normal_adds_shift,
      shifted_position:    req.shifted_position,
      shifted_keeps_shift: req.shifted_keeps_shift
   };

   // Keymap memory: written on load entry, read on key down
   hkm_ram #(
      .WIDTH ($bits(map_entry_type)),
      .DEPTH (KEY_CODES)
   ) u_keymap_ram (
      .clock   (clock),
      .wr_en   (accept && cmd == CMD_LOAD_ENTRY && code_valid),
      .wr_addr (idx),
      .wr_data (load_entry),
      .rd_en   (accept && cmd == CMD_KEY_DOWN),
      .rd_addr (idx),
      .rd_data (ram_rd_data)
   );

   // Classify and track written entries and key history
   always_comb begin
      f1_op_in.command       = cmd;
      f1_op_in.code_valid    = code_valid;
      f1_op_in.shift_code    = (req.key_code == SHIFT_LEFT_CODE) ||
                               (req.key_code == SHIFT_RIGHT_CODE);
      f1_op_in.shift_slot    = req.key_code == SHIFT_LEFT_CODE;
      f1_op_in.newly_pressed = (cmd == CMD_KEY_DOWN) && code_valid && !keys_last_ff[idx];
      f1_op_in.joy_one       = joy_for_port(port_one_src_ff, key_set_one_ff,
                                            key_set_two_ff, req.key_code);
      f1_op_in.joy_two       = joy_for_port(port_two_src_ff, key_set_one_ff,
                                            key_set_two_ff, req.key_code);
      f1_op_in.caps_lock     = req.caps_lock;
      f1_op_in.entry         = load_entry;

      f1_valid_in  = advance ? req.valid : f1_valid_ff;
      written_in   = written_ff;
      keys_this_in = keys_this_ff;
      keys_last_in = keys_last_ff;

      if (accept) begin
         case (cmd)
            CMD_LOAD_ENTRY: begin
               if (code_valid) begin
                  written_in[idx] = 1'b1;
               end
            end
            CMD_FRAME_START: begin
               keys_this_in = '0;
            end
            CMD_KEY_DOWN: begin
               if (code_valid) begin
                  keys_this_in[idx] = 1'b1;
               end
            end
            CMD_FRAME_END: begin
               keys_last_in = keys_this_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         written_ff   <= '0;
         keys_this_ff <= '0;
         keys_last_ff <= '0;
      end else begin
         f1_valid_ff  <= f1_valid_in;
         written_ff   <= written_in;
         keys_this_ff <= keys_this_in;
         keys_last_ff <= keys_last_in;
      end
   end

   // Stage payload, loaded on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         f1_op_ff       <= f1_op_in;
         f1_from_ram_ff <= cmd == CMD_KEY_DOWN;
         f1_written_ff  <= code_valid && written_ff[idx];
      end
   end

   // Merge the keymap read into the queued operation
   always_comb begin
      push_op = f1_op_ff;
      if (f1_from_ram_ff) begin
         push_op.entry = f1_written_ff ? map_entry_type'(ram_rd_data) : MAP_ENTRY_RESET;
      end
   end

   assign push_valid = f1_valid_ff;

endmodule

@@ design/hkm_queue.sv @@
// ============================================================================
// hkm_queue: short operation queue
// Decouples the classify stage from the matrix update stage.
// ============================================================================
module hkm_queue import hkm_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic   clock,
   input  logic   reset,
   input  logic   push_valid,
   output logic   push_ready,
   input  op_type push_op,
   output logic   pop_valid,
   input  logic   pop_ready,
   output op_type pop_op
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   op_type           slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_op     = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed operation
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

@@ design/hkm_back.sv @@
// ============================================================================
// hkm_back: matrix update stage
// Applies queued operations to the emulated matrix, joystick words and
// shift state, and drives the result register.
// ============================================================================
module hkm_back import hkm_pkg::*; #(
   parameter int MATRIX_ROWS = MATRIX_ROWS_DEF,
   parameter int MATRIX_COLS = MATRIX_COLS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      pop_valid,
   output logic      pop_ready,
   input  op_type    pop_op,
   hkm_rsp_if.source rsp
);

   localparam logic [4:0] ROWS_LIM = 5'(MATRIX_ROWS);
   localparam logic [4:0] COLS_LIM = 5'(MATRIX_COLS);
   localparam logic [7:0] COLS_MUL = 8'(MATRIX_COLS);

   logic [MATRIX_W-1:0] matrix_ff, matrix_in;
   logic [MATRIX_W-1:0] shift_mask_ff, shift_mask_in;
   logic [JOY_W-1:0]    joy_one_ff, joy_one_in;
   logic [JOY_W-1:0]    joy_two_ff, joy_two_in;
   logic                shift_held_ff, shift_held_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_newly_ff, rsp_newly_in;
   logic                rsp_frame_ff, rsp_frame_in;
   logic [MATRIX_W-1:0] rsp_matrix_ff, rsp_matrix_in;
   logic [JOY_W-1:0]    rsp_joy_one_ff, rsp_joy_one_in;
   logic [JOY_W-1:0]    rsp_joy_two_ff, rsp_joy_two_in;

   logic                fire;
   logic                held;
   map_entry_type       entry;

   // Matrix bit of a packed row/column position, zero when out of bounds
   function automatic logic [MATRIX_W-1:0] position_mask(input logic [POS_W-1:0] pos);
      logic [3:0]          row;
      logic [3:0]          col;
      logic [7:0]          bit_idx;
      logic [MATRIX_W-1:0] mask;
      row     = pos[7:4];
      col     = pos[3:0];
      bit_idx = {4'b0000, row} * COLS_MUL + {4'b0000, col};
      mask    = '0;
      if ({1'b0, row} < ROWS_LIM && {1'b0, col} < COLS_LIM && bit_idx[7:6] == 2'b00) begin
         mask = MATRIX_W'(1) << bit_idx[5:0];
      end
      return mask;
   endfunction

   assign pop_ready = !rsp_valid_ff || rsp.ready;
   assign fire      = pop_valid && pop_ready;
   assign entry     = pop_op.entry;
   assign held      = shift_held_ff || pop_op.shift_code;

   // Apply the operation and form the result
   always_comb begin
      matrix_in      = matrix_ff;
      shift_mask_in  = shift_mask_ff;
      joy_one_in     = joy_one_ff;
      joy_two_in     = joy_two_ff;
      shift_held_in  = shift_held_ff;
      rsp_newly_in   = 1'b0;
      rsp_frame_in   = 1'b0;
      rsp_matrix_in  = '0;
      rsp_joy_one_in = '0;
      rsp_joy_two_in = '0;
      rsp_valid_in   = fire ? 1'b1 : (rsp.ready ? 1'b0 : rsp_valid_ff);

      if (fire) begin
         case (pop_op.command)
            CMD_LOAD_ENTRY: begin
               // Track the emulated shift key position
               if (pop_op.code_valid && pop_op.shift_slot) begin
                  shift_mask_in = position_mask(entry.normal_position);
               end
            end
            CMD_FRAME_START: begin
               matrix_in     = pop_op.caps_lock ? shift_mask_ff : '0;
               joy_one_in    = '0;
               joy_two_in    = '0;
               shift_held_in = pop_op.caps_lock;
            end
            CMD_KEY_DOWN: begin
               shift_held_in = held;
               joy_one_in    = joy_one_ff | pop_op.joy_one;
               joy_two_in    = joy_two_ff | pop_op.joy_two;
               rsp_newly_in  = pop_op.newly_pressed;
               if (pop_op.code_valid && pop_op.joy_one == '0 && pop_op.joy_two == '0) begin
                  if (!held || entry.shifted_position == NO_POSITION) begin
                     if (entry.normal_position != NO_POSITION) begin
                        matrix_in = matrix_ff | position_mask(entry.normal_position);
                        if (held || entry.normal_adds_shift) begin
                           matrix_in = matrix_in | shift_mask_ff;
                        end
                     end
                  end else begin
                     matrix_in = matrix_ff | position_mask(entry.shifted_position);
                     if (!entry.shifted_keeps_shift) begin
                        matrix_in = matrix_in & ~shift_mask_ff;
                     end
                  end
               end
            end
            CMD_FRAME_END: begin
               rsp_frame_in   = 1'b1;
               rsp_matrix_in  = matrix_ff;
               rsp_joy_one_in = joy_one_ff;
               rsp_joy_two_in = joy_two_ff;
            end
            default: begin
            end
         endcase
      end
   end

   // Control and emulated state
   always_ff @(posedge clock) begin
      if (reset) begin
         matrix_ff     <= '0;
         shift_mask_ff <= '0;
         joy_one_ff    <= '0;
         joy_two_ff    <= '0;
         shift_held_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         matrix_ff     <= matrix_in;
         shift_mask_ff <= shift_mask_in;
         joy_one_ff    <= joy_one_in;
         joy_two_ff    <= joy_two_in;
         shift_held_ff <= shift_held_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload, loaded when an operation completes
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_newly_ff   <= rsp_newly_in;
         rsp_frame_ff   <= rsp_frame_in;
         rsp_matrix_ff  <= rsp_matrix_in;
         rsp_joy_one_ff <= rsp_joy_one_in;
         rsp_joy_two_ff <= rsp_joy_two_in;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.newly_pressed = rsp_newly_ff;
   assign rsp.frame_valid   = rsp_frame_ff;
   assign rsp.key_matrix    = rsp_matrix_ff;
   assign rsp.joystick_one  = rsp_joy_one_ff;
   assign rsp.joystick_two  = rsp_joy_two_ff;

endmodule

@@ design/host_key_to_matrix_mapper_core.sv @@
// ============================================================================
// host_key_to_matrix_mapper_core: host key to emulated keyboard matrix mapper
// Top level: classify stage, operation queue and matrix update stage.
// ============================================================================
// Takes one command transaction per clock when not stalled and returns exactly
// one response transaction per command, in order. A response is registered in
// the classify stage, the operation queue and the result register after its
// command is accepted; the rate of one command per cycle is set by the single
// keymap memory port read in the classify stage and the matrix update in the
// back stage. The keymap memory needs no clearing pass: a written bit per key
// code makes unwritten entries read as unmapped. Write the configuration
// registers only while no command is in flight. Frame end responses carry the
// matrix and joystick words; key down responses carry the newly pressed flag.
module host_key_to_matrix_mapper_core import hkm_pkg::*; #(
   parameter int KEY_CODES   = KEY_CODES_DEF,
   parameter int MATRIX_ROWS = MATRIX_ROWS_DEF,
   parameter int MATRIX_COLS = MATRIX_COLS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   hkm_req_if.sink                req_ch,
   hkm_rsp_if.source              rsp_ch,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   logic   push_valid, push_ready;
   op_type push_op;
   logic   pop_valid, pop_ready;
   op_type pop_op;

   // Accept and classify
   hkm_front #(
      .KEY_CODES (KEY_CODES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_op          (push_op)
   );

   // Decouple the two halves
   hkm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_op     (pop_op)
   );

   // Update matrix and respond
   hkm_back #(
      .MATRIX_ROWS (MATRIX_ROWS),
      .MATRIX_COLS (MATRIX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_op    (pop_op),
      .rsp       (rsp_ch)
   );

endmodule

@@ design/hkm_checker.sv @@
// ============================================================================
// hkm_checker: port level checks of the key to matrix mapper
// Watches the response channel over time; bound to the top level.
// ============================================================================
module hkm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        newly_pressed,
   input logic        frame_valid,
   input logic [63:0] key_matrix,
   input logic [4:0]  joystick_one,
   input logic [4:0]  joystick_two
);

   // No response survives reset
   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_matrix) &&
         $stable(frame_valid) && $stable(newly_pressed) &&
         $stable(joystick_one) && $stable(joystick_two))
      else $error("stalled response changed");

   // Only frame end responses carry matrix and joystick words
   a_nonframe_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !frame_valid |-> key_matrix == '0 && joystick_one == '0 &&
         joystick_two == '0)
      else $error("matrix data on a non-frame response");

   // A frame end response never reports a new key press
   a_frame_not_newly: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_valid |-> !newly_pressed)
      else $error("newly pressed on a frame end response");

endmodule

bind host_key_to_matrix_mapper_core hkm_checker u_hkm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .newly_pressed (rsp_ch.newly_pressed),
   .frame_valid   (rsp_ch.frame_valid),
   .key_matrix    (rsp_ch.key_matrix),
   .joystick_one  (rsp_ch.joystick_one),
   .joystick_two  (rsp_ch.joystick_two)
);

@@ tb/testbench.sv @@
// ============================================================================
// testbench: self-checking bench for host_key_to_matrix_mapper_core
// Drives keymap loads, scan frames, key downs and frame ends through the
// request channel and checks every response against a cycle-free model of
// the keymap, matrix and joystick state. Both channels idle and stall at
// random, the receiver holds off once for a long stretch, and the joystick
// registers are rewritten between phases.
// ============================================================================
module testbench import hkm_pkg::*;;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned PHASE_ITEMS   = 285;
   localparam int unsigned HOLD_TRIGGER  = 300;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned LATENCY_SLACK = 10;

   typedef struct packed {
      command_type      command;
      logic [CODE_W-1:0] key_code;
      logic [POS_W-1:0] normal_position;
      logic             normal_adds_shift;
      logic [POS_W-1:0] shifted_position;
      logic             shifted_keeps_shift;
      logic             caps_lock;
   } key_command_type;

   typedef struct packed {
      logic                newly_pressed;
      logic                frame_valid;
      logic [MATRIX_W-1:0] key_matrix;
      logic [JOY_W-1:0]    joystick_one;
      logic [JOY_W-1:0]    joystick_two;
   } matrix_result_type;

   // Keymap, matrix and joystick state with the queue of expected responses
   class keymap_scoreboard;
      map_entry_type       keymap [KEY_CODES_DEF];
      logic [MATRIX_W-1:0] matrix;
      logic [JOY_W-1:0]    joy_one;
      logic [JOY_W-1:0]    joy_two;
      bit                  shift_down;
      bit [KEY_CODES_DEF-1:0] held_now;
      bit [KEY_CODES_DEF-1:0] held_before;
      logic [KEY_SET_W-1:0] set_one;
      logic [KEY_SET_W-1:0] set_two;
      logic [SOURCE_W-1:0]  src_one;
      logic [SOURCE_W-1:0]  src_two;
      matrix_result_type   expected_q [$];
      int unsigned         mismatches;

      function new();
         foreach (keymap[i]) keymap[i] = MAP_ENTRY_RESET;
         matrix      = '0;
         joy_one     = '0;
         joy_two     = '0;
         shift_down  = 1'b0;
         held_now    = '0;
         held_before = '0;
         set_one     = KEY_SET_ONE_RESET;
         set_two     = KEY_SET_TWO_RESET;
         src_one     = SRC_NONE;
         src_two     = SRC_NONE;
         mismatches  = 0;
      endfunction

      function void write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_KEYS_SET_ONE: set_one = data;
            CSR_KEYS_SET_TWO: set_two = data;
            CSR_PORT_ONE_SRC: src_one = data[SOURCE_W-1:0];
            CSR_PORT_TWO_SRC: src_two = data[SOURCE_W-1:0];
            default: ;
         endcase
      endfunction

      // Matrix bit at a packed row/column position; nothing when off the matrix
      function logic [MATRIX_W-1:0] matrix_bit(logic [POS_W-1:0] pos);
         int unsigned row;
         int unsigned col;
         int unsigned idx;
         row = pos[7:4];
         col = pos[3:0];
         if (row >= MATRIX_ROWS_DEF || col >= MATRIX_COLS_DEF) return '0;
         idx = row * MATRIX_COLS_DEF + col;
         if (idx >= MATRIX_W) return '0;
         return MATRIX_W'(1) << idx;
      endfunction

      function logic [MATRIX_W-1:0] shift_bit();
         return matrix_bit(keymap[SHIFT_LEFT_CODE].normal_position);
      endfunction

      // First slot of the set holding the code wins
      function logic [JOY_W-1:0] set_hit(logic [KEY_SET_W-1:0] key_set,
                                         logic [CODE_W-1:0] code);
         for (int i = 0; i < JOY_W; i++) begin
            if (key_set[i*CODE_W +: CODE_W] == code) return JOY_W'(1) << i;
         end
         return '0;
      endfunction

      function logic [JOY_W-1:0] port_bits(logic [SOURCE_W-1:0] src,
                                           logic [CODE_W-1:0] code);
         if (src == SRC_SET_ONE) return set_hit(set_one, code);
         if (src == SRC_SET_TWO) return set_hit(set_two, code);
         return '0;
      endfunction

      // Advance the state by one accepted transaction and queue its response
      function void note_command(key_command_type cmd);
         matrix_result_type res;
         map_entry_type  ent;
         logic [JOY_W-1:0] j1;
         logic [JOY_W-1:0] j2;
         res = '0;
         case (cmd.command)
            CMD_LOAD_ENTRY: begin
               ent.normal_position     = cmd.normal_position;
               ent.normal_adds_shift   = cmd.normal_adds_shift;
               ent.shifted_position    = cmd.shifted_position;
               ent.shifted_keeps_shift = cmd.shifted_keeps_shift;
               keymap[cmd.key_code]    = ent;
            end
            CMD_FRAME_START: begin
               matrix     = '0;
               joy_one    = '0;
               joy_two    = '0;
               held_now   = '0;
               shift_down = cmd.caps_lock;
               if (shift_down) matrix |= shift_bit();
            end
            CMD_KEY_DOWN: begin
               j1 = port_bits(src_one, cmd.key_code);
               j2 = port_bits(src_two, cmd.key_code);
               if (cmd.key_code == SHIFT_LEFT_CODE || cmd.key_code == SHIFT_RIGHT_CODE)
                  shift_down = 1'b1;
               joy_one |= j1;
               joy_two |= j2;
               res.newly_pressed = !held_before[cmd.key_code];
               held_now[cmd.key_code] = 1'b1;
               if (j1 == '0 && j2 == '0) begin
                  ent = keymap[cmd.key_code];
                  if (!shift_down || ent.shifted_position == NO_POSITION) begin
                     if (ent.normal_position != NO_POSITION) begin
                        matrix |= matrix_bit(ent.normal_position);
                        if (shift_down || ent.normal_adds_shift) matrix |= shift_bit();
                     end
                  end else begin
                     matrix |= matrix_bit(ent.shifted_position);
                     if (!ent.shifted_keeps_shift) matrix &= ~shift_bit();
                  end
               end
            end
            default: begin
               res.frame_valid  = 1'b1;
               res.key_matrix   = matrix;
               res.joystick_one = joy_one;
               res.joystick_two = joy_two;
               held_before      = held_now;
            end
         endcase
         expected_q.push_back(res);
      endfunction

      task report_mismatch(string what, logic [MATRIX_W-1:0] want, logic [MATRIX_W-1:0] seen);
         $display("mismatch on %s: expected %h, got %h", what, want, seen);
         mismatches++;
      endtask

      task check_result(matrix_result_type got);
         matrix_result_type want;
         if (expected_q.size() == 0) begin
            report_mismatch("response with nothing outstanding", '0, got.key_matrix);
            return;
         end
         want = expected_q.pop_front();
         if (got.newly_pressed !== want.newly_pressed)
            report_mismatch("newly_pressed", want.newly_pressed, got.newly_pressed);
         if (got.frame_valid !== want.frame_valid)
            report_mismatch("frame_valid", want.frame_valid, got.frame_valid);
         if (got.key_matrix !== want.key_matrix)
            report_mismatch("key_matrix", want.key_matrix, got.key_matrix);
         if (got.joystick_one !== want.joystick_one)
            report_mismatch("joystick_one", want.joystick_one, got.joystick_one);
         if (got.joystick_two !== want.joystick_two)
            report_mismatch("joystick_two", want.joystick_two, got.joystick_two);
      endtask

      function int unsigned pending_count();
         return expected_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   hkm_req_if req_ch ();
   hkm_rsp_if rsp_ch ();

   keymap_scoreboard sb = new();
   int unsigned accepted_items = 0;
   int unsigned cycle_count = 0;
   bit          quiet_frame = 1'b0;
   int unsigned code_pool [$];

   host_key_to_matrix_mapper_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_ch),
      .rsp_ch           (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Stop a hung run
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Mostly short gaps, now and then a long one
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [POS_W-1:0] random_position();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return {4'($urandom_range(0, 7)), 4'($urandom_range(0, 7))};
      if (r < 85) return NO_POSITION;
      return POS_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      if ($urandom_range(0, 3) != 0)
         return CODE_W'(code_pool[$urandom_range(0, code_pool.size() - 1)]);
      return CODE_W'($urandom_range(0, 127));
   endfunction

   // Key sets lean on the shift keys and the code extremes, duplicates allowed
   function automatic logic [KEY_SET_W-1:0] random_key_set();
      logic [KEY_SET_W-1:0] s;
      for (int i = 0; i < JOY_W; i++) begin
         case ($urandom_range(0, 7))
            0: s[i*CODE_W +: CODE_W] = SHIFT_LEFT_CODE;
            1: s[i*CODE_W +: CODE_W] = SHIFT_RIGHT_CODE;
            2: s[i*CODE_W +: CODE_W] = '0;
            3: s[i*CODE_W +: CODE_W] = '1;
            default: s[i*CODE_W +: CODE_W] = CODE_W'($urandom_range(0, 127));
         endcase
      end
      return s;
   endfunction

   function automatic key_command_type random_command();
      key_command_type c;
      c.command             = command_type'($urandom_range(0, 3));
      c.key_code            = CODE_W'($urandom_range(0, 127));
      c.normal_position     = random_position();
      c.normal_adds_shift   = 1'($urandom_range(0, 1));
      c.shifted_position    = random_position();
      c.shifted_keeps_shift = 1'($urandom_range(0, 1));
      c.caps_lock           = 1'($urandom_range(0, 1));
      return c;
   endfunction

   function automatic key_command_type make_command(command_type cmd, logic [CODE_W-1:0] code,
                                                    logic [POS_W-1:0] npos, logic nadd,
                                                    logic [POS_W-1:0] spos, logic skeep,
                                                    logic caps);
      key_command_type c;
      c.command             = cmd;
      c.key_code            = code;
      c.normal_position     = npos;
      c.normal_adds_shift   = nadd;
      c.shifted_position    = spos;
      c.shifted_keeps_shift = skeep;
      c.caps_lock           = caps;
      return c;
   endfunction

   // Offer one transaction after an optional gap, hold it until accepted
   task automatic send_command(key_command_type cmd);
      int unsigned g;
      g = quiet_frame ? 0 : gap_len();
      if (g > 0) begin
         req_ch.valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_ch.command             <= cmd.command;
      req_ch.key_code            <= cmd.key_code;
      req_ch.normal_position     <= cmd.normal_position;
      req_ch.normal_adds_shift   <= cmd.normal_adds_shift;
      req_ch.shifted_position    <= cmd.shifted_position;
      req_ch.shifted_keeps_shift <= cmd.shifted_keeps_shift;
      req_ch.caps_lock           <= cmd.caps_lock;
      req_ch.valid               <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sb.note_command(cmd);
      accepted_items++;
      @(negedge clock);
   endtask

   task automatic send_key(command_type cmd, logic [CODE_W-1:0] code);
      key_command_type c;
      c = random_command();
      c.command  = cmd;
      c.key_code = code;
      send_command(c);
   endtask

   task automatic send_frame_start(logic caps);
      key_command_type c;
      c = random_command();
      c.command   = CMD_FRAME_START;
      c.caps_lock = caps;
      send_command(c);
   endtask

   // Wait until every response is back and the block has gone quiet
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.pending_count() != 0) @(negedge clock);
      repeat (LATENCY_SLACK) @(negedge clock);
   endtask

   // Write all four registers on back-to-back cycles while the block is idle
   task automatic apply_settings(logic [KEY_SET_W-1:0] s1, logic [KEY_SET_W-1:0] s2,
                                 logic [SOURCE_W-1:0] p1, logic [SOURCE_W-1:0] p2);
      csr_index_type idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      idx = '{CSR_KEYS_SET_ONE, CSR_KEYS_SET_TWO, CSR_PORT_ONE_SRC, CSR_PORT_TWO_SRC};
      val = '{s1, s2, CSR_DATA_W'(p1), CSR_DATA_W'(p2)};
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= idx[i];
         csr_write_data   <= val[i];
         sb.write_register(idx[i], val[i]);
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   // Codes that hit the shift keys, the extremes and the joystick sets
   task automatic rebuild_pool();
      code_pool.delete();
      code_pool.push_back(SHIFT_LEFT_CODE);
      code_pool.push_back(SHIFT_RIGHT_CODE);
      code_pool.push_back(0);
      code_pool.push_back(127);
      for (int i = 0; i < JOY_W; i++) begin
         code_pool.push_back(sb.set_one[i*CODE_W +: CODE_W]);
         code_pool.push_back(sb.set_two[i*CODE_W +: CODE_W]);
      end
      repeat (4) code_pool.push_back($urandom_range(0, 127));
   endtask

   task automatic load_random_entry(logic [CODE_W-1:0] code);
      key_command_type c;
      c = random_command();
      c.command  = CMD_LOAD_ENTRY;
      c.key_code = code;
      send_command(c);
   endtask

   // One scan frame, sometimes broken or replaced by noise
   task automatic run_frame();
      int unsigned r;
      int unsigned n;
      quiet_frame = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 8) begin
         repeat ($urandom_range(1, 4)) send_command(random_command());
      end else begin
         if (r >= 12) send_frame_start(($urandom_range(0, 3) == 0));
         n = $urandom_range(0, 8);
         repeat (n) begin
            if ($urandom_range(0, 9) == 0) load_random_entry(pick_code());
            else send_key(CMD_KEY_DOWN, pick_code());
         end
         if (r < 95) send_key(CMD_FRAME_END, pick_code());
      end
      quiet_frame = 1'b0;
   endtask

   task automatic run_phase(logic [KEY_SET_W-1:0] s1, logic [KEY_SET_W-1:0] s2,
                            logic [SOURCE_W-1:0] p1, logic [SOURCE_W-1:0] p2);
      int unsigned start;
      drain();
      apply_settings(s1, s2, p1, p2);
      rebuild_pool();
      foreach (code_pool[i]) load_random_entry(CODE_W'(code_pool[i]));
      start = accepted_items;
      while (accepted_items - start < PHASE_ITEMS) run_frame();
   endtask

   // Short shifted and normal mappings, joystick keys, out of range positions
   task automatic run_directed();
      key_command_type d [$];
      d.push_back(make_command(CMD_LOAD_ENTRY, SHIFT_LEFT_CODE, 8'h17, 0, NO_POSITION, 0, 0));
      d.push_back(make_command(CMD_LOAD_ENTRY, SHIFT_RIGHT_CODE, 8'h64, 0, NO_POSITION, 0, 0));
      d.push_back(make_command(CMD_LOAD_ENTRY, 7'd0, 8'h00, 1, 8'h77, 1, 0));
      d.push_back(make_command(CMD_LOAD_ENTRY, 7'd127, 8'h77, 0, 8'h08, 0, 1));
      d.push_back(make_command(CMD_LOAD_ENTRY, 7'd10, 8'h80, 1, 8'h23, 0, 0));
      d.push_back(make_command(CMD_LOAD_ENTRY, 7'd11, NO_POSITION, 0, 8'h45, 1, 0));
      d.push_back(make_command(CMD_FRAME_START, 7'd0, '0, 0, '0, 0, 1));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd0, '1, 1, '1, 1, 1));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd10, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd108, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd83, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_FRAME_END, 7'd0, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_FRAME_START, 7'd0, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd0, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd0, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd11, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, SHIFT_RIGHT_CODE, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd127, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd11, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_FRAME_END, 7'd0, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_FRAME_END, 7'd127, '1, 1, '1, 1, 1));
      d.push_back(make_command(CMD_KEY_DOWN, 7'd5, '0, 0, '0, 0, 0));
      d.push_back(make_command(CMD_LOAD_ENTRY, SHIFT_LEFT_CODE, NO_POSITION, 1, 8'h00, 1, 0));
      d.push_back(make_command(CMD_FRAME_START, 7'd0, '0, 0, '0, 0, 1));
      d.push_back(make_command(CMD_FRAME_END, 7'd0, '0, 0, '0, 0, 0));
      apply_settings(KEY_SET_ONE_RESET, KEY_SET_TWO_RESET, SRC_SET_ONE, SRC_SET_TWO);
      foreach (d[i]) send_command(d[i]);
   endtask

   // Response ready: random stalls, idle-free stretches and one long hold-off
   initial begin
      bit held_off;
      int unsigned s;
      held_off = 1'b0;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && accepted_items >= HOLD_TRIGGER) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         s = gap_len();
         if (s > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (s) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(30, 90)) @(negedge clock);
         else repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   // Check every accepted response
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         sb.check_result('{newly_pressed: rsp_ch.newly_pressed,
                           frame_valid:   rsp_ch.frame_valid,
                           key_matrix:    rsp_ch.key_matrix,
                           joystick_one:  rsp_ch.joystick_one,
                           joystick_two:  rsp_ch.joystick_two});
      end
   end

   initial begin
      reset                      = 1'b1;
      csr_write_enable           = 1'b0;
      csr_index                  = CSR_KEYS_SET_ONE;
      csr_write_data             = '0;
      req_ch.valid               = 1'b0;
      req_ch.command             = CMD_LOAD_ENTRY;
      req_ch.key_code            = '0;
      req_ch.normal_position     = '0;
      req_ch.normal_adds_shift   = 1'b0;
      req_ch.shifted_position    = '0;
      req_ch.shifted_keeps_shift = 1'b0;
      req_ch.caps_lock           = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      run_directed();
      run_phase(random_key_set(), random_key_set(), SRC_NONE, SRC_NONE);
      run_phase(random_key_set(), random_key_set(), SRC_SET_TWO, SRC_SET_ONE);
      run_phase('1, '0, 2'd3, SRC_SET_TWO);
      run_phase(random_key_set(), random_key_set(),
                SOURCE_W'($urandom_range(0, 3)), SOURCE_W'($urandom_range(0, 3)));
      run_phase(KEY_SET_ONE_RESET, KEY_SET_TWO_RESET, SRC_SET_ONE, SRC_SET_ONE);

      // Let the last responses come back before judging
      req_ch.valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_count() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
